[hdl/dcqcn_pkg.sv]
`timescale 1ns / 1ps

package dcqcn_pkg;

	// request codes
	localparam logic [1:0] REQ_CNP  = 2'd0;
	localparam logic [1:0] REQ_TICK = 2'd1;
	localparam logic [1:0] REQ_SEND = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_LINE_RATE = 3'd0;
	localparam logic [2:0] REG_MIN_RATE  = 3'd1;
	localparam logic [2:0] REG_RATE_INC  = 3'd2;
	localparam logic [2:0] REG_TIMER     = 3'd3;
	localparam logic [2:0] REG_GAIN      = 3'd4;

	// register reset values
	localparam logic [19:0] LINE_RATE_RST = 20'd400000;
	localparam logic [19:0] MIN_RATE_RST  = 20'd100;
	localparam logic [19:0] RATE_INC_RST  = 20'd40;
	localparam logic [15:0] TIMER_RST     = 16'd55;
	localparam logic [3:0]  GAIN_RST      = 4'd4;

	// fixed point constants
	localparam logic [16:0] ALPHA_ONE     = 17'd65536;
	localparam logic [17:0] ALPHA_TWO     = 18'd131072;
	localparam logic [28:0] GAP_MAX       = 29'h1FFFFFFF;
	localparam logic [16:0] BYTE_OVERHEAD = 17'd12;
	localparam logic [17:0] NS_PER_BYTE8  = 18'd8000;
	localparam logic [9:0]  REARM_NUM     = 10'd1000;
	localparam logic [9:0]  REARM_DEN     = 10'd999;

	// per-flow state word
	typedef struct packed {
		logic [19:0] rate;
		logic [16:0] alpha;
		logic        cnp_seen;
		logic        active;
		logic [15:0] left;
	} flow_entry_t;

endpackage

[hdl/dcqcn_ram.sv]
`timescale 1ns / 1ps

module dcqcn_ram #(
	parameter int WIDTH = 55,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[hdl/dcqcn_flow_rate_controller_top.sv]
`timescale 1ns / 1ps
// cnp item: states RD, EXEC, MUL, CNPWR and OUT in order; next item taken once the result is registered
// send item: states RD, EXEC, MUL and DIVI, then the 29-step bit-serial divider
// (skipped at zero rate), then OUT; next item taken once the result is registered
// tick item: each flow in turn is read then updated; next item taken after the last flow
// one item at a time; a result still held by the receiver delays the next result
// reset: async active low, then a clearing pass over all NUM_FLOWS entries with no item taken

module dcqcn_flow_rate_controller_top #(
	parameter int NUM_FLOWS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [9:0]  flow,
	input  logic [15:0] pkt_bytes,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [9:0]  out_flow,
	output logic [19:0] rate_mbps,
	output logic [16:0] alpha_q16,
	output logic [28:0] gap_ns
);

	localparam int AW = $clog2(NUM_FLOWS);
	localparam int EW = $bits(dcqcn_pkg::flow_entry_t);
	localparam logic [AW-1:0] LAST_FLOW = AW'(NUM_FLOWS - 1);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_EXEC  = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_CNPWR = 4'd5;
	localparam logic [3:0] ST_DIVI  = 4'd6;
	localparam logic [3:0] ST_DIV   = 4'd7;
	localparam logic [3:0] ST_OUT   = 4'd8;
	localparam logic [3:0] ST_TRD   = 4'd9;
	localparam logic [3:0] ST_TEXE  = 4'd10;

	logic [3:0]  state_q;
	logic [19:0] line_rate_q, floor_rate_q, rate_inc_q;
	logic [15:0] timer_q;
	logic [3:0]  gain_q;

	logic [AW-1:0] idx_q, addr_q;
	logic [9:0]    flow_q;
	logic          is_cnp_q;
	logic [15:0]   bytes_q;
	logic [19:0]   mul_a_q;
	logic [17:0]   mul_b_q;
	logic [37:0]   prod_q;
	logic [16:0]   alpha_new_q;
	logic [19:0]   div_d_q;
	logic [28:0]   div_n_q;
	logic [19:0]   div_r_q;
	logic [4:0]    div_cnt_q;
	logic [19:0]   res_rate_q;
	logic [16:0]   res_alpha_q;
	logic [28:0]   res_gap_q;
	logic          out_valid_q;

	dcqcn_pkg::flow_entry_t rd_ent, wr_ent, clr_ent;
	logic [EW-1:0] ram_rd_data;
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;

	logic [15:0] period;
	logic        in_acc, flow_ok;
	logic [19:0] eff_rate;
	logic [17:0] cnp_alpha;
	logic [16:0] cnp_alpha_cap;
	logic [19:0] cnp_rate_raw, cnp_rate;
	logic [16:0] dec_alpha;
	logic [15:0] tick_left;
	logic [20:0] inc_sum;
	logic [19:0] tick_rate;
	logic        rearm;
	dcqcn_pkg::flow_entry_t tick_ent;
	logic [20:0] div_trial;
	logic        div_ge;
	logic [28:0] div_n_next;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign flow_ok   = (32'(flow) < 32'(NUM_FLOWS));
	assign period    = (timer_q == 16'd0) ? 16'd1 : timer_q;

	assign rd_ent = dcqcn_pkg::flow_entry_t'(ram_rd_data);
	assign eff_rate = (rd_ent.rate == 20'd0) ? line_rate_q : rd_ent.rate;

	// alpha increase on cnp, capped at one
	assign cnp_alpha = 18'(rd_ent.alpha) - 18'(rd_ent.alpha >> gain_q)
		+ 18'(dcqcn_pkg::ALPHA_ONE >> gain_q);
	assign cnp_alpha_cap = (cnp_alpha > 18'(dcqcn_pkg::ALPHA_ONE)) ?
		dcqcn_pkg::ALPHA_ONE : cnp_alpha[16:0];

	// multiplicative decrease, floored at min rate
	assign cnp_rate_raw = prod_q[36:17];
	assign cnp_rate = (cnp_rate_raw < floor_rate_q) ? floor_rate_q : cnp_rate_raw;

	// timer walk update for one flow
	assign dec_alpha = rd_ent.alpha - (rd_ent.alpha >> gain_q);
	assign tick_left = (rd_ent.left != 16'd0) ? rd_ent.left - 16'd1 : 16'd0;
	assign inc_sum   = 21'(rd_ent.rate) + 21'(rate_inc_q);
	assign tick_rate = rd_ent.cnp_seen ? rd_ent.rate :
		((inc_sum > 21'(line_rate_q)) ? line_rate_q : inc_sum[19:0]);
	assign rearm = (30'(tick_rate) * 30'(dcqcn_pkg::REARM_NUM))
		< (30'(line_rate_q) * 30'(dcqcn_pkg::REARM_DEN));

	always_comb begin
		tick_ent = rd_ent;
		if (tick_left != 16'd0) begin
			tick_ent.left = tick_left;
		end else begin
			tick_ent.alpha    = dec_alpha;
			tick_ent.cnp_seen = 1'b0;
			tick_ent.rate     = tick_rate;
			if (rearm) begin
				tick_ent.left = period;
			end else begin
				tick_ent.active = 1'b0;
				tick_ent.left   = 16'd0;
			end
		end
	end

	// restoring divider step
	assign div_trial  = {div_r_q, div_n_q[28]};
	assign div_ge     = (div_trial >= 21'(div_d_q));
	assign div_n_next = {div_n_q[27:0], div_ge};

	// table write selection
	always_comb begin
		clr_ent.rate     = 20'd0;
		clr_ent.alpha    = dcqcn_pkg::ALPHA_ONE;
		clr_ent.cnp_seen = 1'b0;
		clr_ent.active   = 1'b0;
		clr_ent.left     = 16'd0;
		wr_ent    = clr_ent;
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_CNPWR: begin
				ram_we          = 1'b1;
				ram_waddr       = addr_q;
				wr_ent.rate     = cnp_rate;
				wr_ent.alpha    = alpha_new_q;
				wr_ent.cnp_seen = 1'b1;
				wr_ent.active   = 1'b1;
				wr_ent.left     = period;
			end
			ST_TEXE: begin
				ram_we = rd_ent.active;
				wr_ent = tick_ent;
			end
			default: begin
			end
		endcase
	end

	assign ram_re    = (state_q == ST_RD) || (state_q == ST_TRD);
	assign ram_raddr = (state_q == ST_TRD) ? idx_q : addr_q;

	dcqcn_ram #(
		.WIDTH(EW),
		.DEPTH(NUM_FLOWS)
	) u_flow_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(ram_waddr),
		.wr_data(wr_ent),
		.rd_en  (ram_re),
		.rd_addr(ram_raddr),
		.rd_data(ram_rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_rate_q  <= dcqcn_pkg::LINE_RATE_RST;
			floor_rate_q <= dcqcn_pkg::MIN_RATE_RST;
			rate_inc_q   <= dcqcn_pkg::RATE_INC_RST;
			timer_q      <= dcqcn_pkg::TIMER_RST;
			gain_q       <= dcqcn_pkg::GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dcqcn_pkg::REG_LINE_RATE: line_rate_q  <= cfg_data;
				dcqcn_pkg::REG_MIN_RATE:  floor_rate_q <= cfg_data;
				dcqcn_pkg::REG_RATE_INC:  rate_inc_q   <= cfg_data;
				dcqcn_pkg::REG_TIMER:     timer_q      <= cfg_data[15:0];
				dcqcn_pkg::REG_GAIN:      gain_q       <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == LAST_FLOW) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (req_type == dcqcn_pkg::REQ_TICK) begin
							idx_q   <= '0;
							state_q <= ST_TRD;
						end else if ((req_type == dcqcn_pkg::REQ_CNP ||
								req_type == dcqcn_pkg::REQ_SEND) && flow_ok) begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= is_cnp_q ? ST_CNPWR : ST_DIVI;
				end
				ST_CNPWR: begin
					state_q <= ST_OUT;
				end
				ST_DIVI: begin
					state_q <= (div_d_q == 20'd0) ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q == 5'd28) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TRD: begin
					state_q <= ST_TEXE;
				end
				ST_TEXE: begin
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_TRD;
					if (idx_q == LAST_FLOW) begin
						idx_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				addr_q   <= AW'(flow);
				flow_q   <= flow;
				is_cnp_q <= (req_type == dcqcn_pkg::REQ_CNP);
				bytes_q  <= pkt_bytes;
			end
			ST_EXEC: begin
				if (is_cnp_q) begin
					mul_a_q     <= eff_rate;
					mul_b_q     <= dcqcn_pkg::ALPHA_TWO - 18'(cnp_alpha_cap);
					alpha_new_q <= cnp_alpha_cap;
				end else begin
					mul_a_q     <= 20'(17'(bytes_q) + dcqcn_pkg::BYTE_OVERHEAD);
					mul_b_q     <= dcqcn_pkg::NS_PER_BYTE8;
					div_d_q     <= eff_rate;
					res_rate_q  <= eff_rate;
					res_alpha_q <= rd_ent.alpha;
				end
			end
			ST_MUL: begin
				prod_q <= 38'(mul_a_q) * 38'(mul_b_q);
			end
			ST_CNPWR: begin
				res_rate_q  <= (cnp_rate == 20'd0) ? line_rate_q : cnp_rate;
				res_alpha_q <= alpha_new_q;
				res_gap_q   <= 29'd0;
			end
			ST_DIVI: begin
				div_n_q   <= prod_q[28:0];
				div_r_q   <= 20'd0;
				div_cnt_q <= 5'd0;
				res_gap_q <= dcqcn_pkg::GAP_MAX;
			end
			ST_DIV: begin
				div_r_q   <= div_ge ? 20'(div_trial - 21'(div_d_q)) : div_trial[19:0];
				div_n_q   <= div_n_next;
				div_cnt_q <= div_cnt_q + 5'd1;
				res_gap_q <= div_n_next;
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
			out_flow  <= flow_q;
			rate_mbps <= res_rate_q;
			alpha_q16 <= res_alpha_q;
			gap_ns    <= res_gap_q;
		end
	end

	assign out_valid = out_valid_q;

	// the table is not written while waiting for an item
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !ram_we)
		else $error("flow table written while idle");

	// a held result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && !out_ready) |=> (state_q == ST_OUT))
		else $error("result dropped while output stalled");

	// divider never runs past its last step
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_cnt_q <= 5'd28))
		else $error("divider step count overrun");

	// a finished walk always returns to idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TEXE && idx_q == LAST_FLOW) |=> (state_q == ST_IDLE))
		else $error("timer walk did not end at last flow");

endmodule
